// ===== sv/rpd_pkg.sv =====
package rpd_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned WIDTH_CFG_W = 16;
  localparam int unsigned LOW_PCT_W = 7;
  localparam int unsigned HIGH_PCT_W = 8;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LOW_PROD_W = TIME_W + LOW_PCT_W;
  localparam int unsigned HIGH_PROD_W = TIME_W + HIGH_PCT_W;
  localparam int unsigned SCALED_W = TIME_W + 7;
  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_MIN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_MAX = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_PCT = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_PCT = 2'd3;

  localparam logic [WIDTH_CFG_W-1:0] WIDTH_MIN_RST = 16'd1097;
  localparam logic [WIDTH_CFG_W-1:0] WIDTH_MAX_RST = 16'd1987;
  localparam logic [LOW_PCT_W-1:0] LOW_PCT_RST = 7'd85;
  localparam logic [HIGH_PCT_W-1:0] HIGH_PCT_RST = 8'd115;

  localparam logic [1:0] STARTUP_EDGES = 2'd3;
  localparam logic [3:0] OUTLIER_RUN = 4'd10;
  localparam logic [SCALED_W-1:0] PCT_SCALE = 39'd100;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic [WIDTH_CFG_W-1:0] width_min;
    logic [WIDTH_CFG_W-1:0] width_max;
    logic [LOW_PCT_W-1:0]   period_low_pct;
    logic [HIGH_PCT_W-1:0]  period_high_pct;
  } rpd_cfg_t;

  typedef struct packed {
    logic              command;
    logic              level;
    logic [TIME_W-1:0] time_us;
  } rpd_item_t;

  typedef struct packed {
    logic              started;
    logic              period_outlier;
    logic              width_outlier;
    logic              width_accepted;
    logic              report;
    logic [TIME_W-1:0] width_us;
    logic [TIME_W-1:0] cycle_us;
  } rpd_result_t;

endpackage

// ===== sv/rpd_cfg_regs.sv =====
module rpd_cfg_regs
  import rpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output rpd_cfg_t              cfg
);

  rpd_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_min <= WIDTH_MIN_RST;
      cfg_r.width_max <= WIDTH_MAX_RST;
      cfg_r.period_low_pct <= LOW_PCT_RST;
      cfg_r.period_high_pct <= HIGH_PCT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH_MIN: cfg_r.width_min <= cfg_wdata;
        REG_WIDTH_MAX: cfg_r.width_max <= cfg_wdata;
        REG_LOW_PCT:   cfg_r.period_low_pct <= cfg_wdata[LOW_PCT_W-1:0];
        REG_HIGH_PCT:  cfg_r.period_high_pct <= cfg_wdata[HIGH_PCT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/rpd_decode.sv =====
module rpd_decode
  import rpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  rpd_item_t   item,
  input  rpd_cfg_t    cfg,
  input  logic        out_tready,
  output logic        out_valid,
  output rpd_result_t result
);

  logic [TIME_W-1:0]      width_mark_r, width_mark_nxt;
  logic [TIME_W-1:0]      period_mark_r, period_mark_nxt;
  logic [1:0]             startup_left_r, startup_left_nxt;
  logic [3:0]             outlier_count_r, outlier_count_nxt;
  logic                   rise_bad_r, rise_bad_nxt;
  logic                   fall_bad_r, fall_bad_nxt;
  logic [LOW_PROD_W-1:0]  low_prod_r, low_prod_nxt;
  logic [HIGH_PROD_W-1:0] high_prod_r, high_prod_nxt;
  logic [TIME_W-1:0]      accepted_width_r, accepted_width_nxt;
  logic [TIME_W-1:0]      last_cycle_r, last_cycle_nxt;
  logic                   accepted_r, accepted_nxt;
  logic                   report_r, report_nxt;
  logic                   out_valid_r;

  logic [TIME_W-1:0]   period;
  logic [TIME_W-1:0]   high_time;
  logic [SCALED_W-1:0] period_x100;
  logic [SCALED_W-1:0] period_p1_x100;
  logic                running;
  logic                low_bad;
  logic                high_bad;
  logic                width_ok;

  assign period = item.time_us - period_mark_r;
  assign high_time = item.time_us - width_mark_r;
  assign running = (startup_left_r == 2'd0);

  // window test on the unscaled products: p < floor(x/100) iff 100*(p+1) <= x
  assign period_x100 = SCALED_W'(period) * PCT_SCALE;
  assign period_p1_x100 = period_x100 + PCT_SCALE;
  assign low_bad = (period_p1_x100 <= SCALED_W'(low_prod_r)) && (period != '1);
  assign high_bad = high_prod_r < HIGH_PROD_W'(period_x100);
  assign width_ok = (high_time >= TIME_W'(cfg.width_min)) &&
                    (high_time <= TIME_W'(cfg.width_max));

  always_comb begin
    width_mark_nxt = width_mark_r;
    period_mark_nxt = period_mark_r;
    startup_left_nxt = startup_left_r;
    outlier_count_nxt = outlier_count_r;
    rise_bad_nxt = rise_bad_r;
    fall_bad_nxt = fall_bad_r;
    low_prod_nxt = low_prod_r;
    high_prod_nxt = high_prod_r;
    accepted_width_nxt = accepted_width_r;
    last_cycle_nxt = last_cycle_r;
    accepted_nxt = 1'b0;
    report_nxt = 1'b0;
    priority if (item.command == CMD_RESTART) begin
      startup_left_nxt = STARTUP_EDGES;
      width_mark_nxt = item.time_us;
      period_mark_nxt = item.time_us;
      rise_bad_nxt = 1'b0;
      outlier_count_nxt = 4'd0;
    end else if (item.level) begin
      if (!running) begin
        last_cycle_nxt = high_time;
        width_mark_nxt = item.time_us;
        period_mark_nxt = item.time_us;
        low_prod_nxt = LOW_PROD_W'(period) * LOW_PROD_W'(cfg.period_low_pct);
        high_prod_nxt = HIGH_PROD_W'(period) * HIGH_PROD_W'(cfg.period_high_pct);
      end else if (low_bad || high_bad) begin
        rise_bad_nxt = 1'b1;
        if (outlier_count_r == 4'd0) begin
          outlier_count_nxt = OUTLIER_RUN;
        end else begin
          outlier_count_nxt = outlier_count_r - 4'd1;
          if (outlier_count_r == 4'd1) begin
            period_mark_nxt = item.time_us;
          end
        end
      end else begin
        rise_bad_nxt = 1'b0;
        outlier_count_nxt = 4'd0;
        last_cycle_nxt = high_time;
        width_mark_nxt = item.time_us;
        period_mark_nxt = item.time_us;
      end
    end else begin
      if (!running) begin
        startup_left_nxt = startup_left_r - 2'd1;
      end else if (!rise_bad_r) begin
        report_nxt = 1'b1;
        if (width_ok) begin
          accepted_width_nxt = high_time;
          fall_bad_nxt = 1'b0;
          accepted_nxt = 1'b1;
        end else begin
          fall_bad_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mark_r <= '0;
      period_mark_r <= '0;
      startup_left_r <= STARTUP_EDGES;
      outlier_count_r <= 4'd0;
      rise_bad_r <= 1'b0;
      fall_bad_r <= 1'b0;
      accepted_width_r <= '0;
      last_cycle_r <= '0;
      accepted_r <= 1'b0;
      report_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        width_mark_r <= width_mark_nxt;
        period_mark_r <= period_mark_nxt;
        startup_left_r <= startup_left_nxt;
        outlier_count_r <= outlier_count_nxt;
        rise_bad_r <= rise_bad_nxt;
        fall_bad_r <= fall_bad_nxt;
        accepted_width_r <= accepted_width_nxt;
        last_cycle_r <= last_cycle_nxt;
        accepted_r <= accepted_nxt;
        report_r <= report_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // learned window products, meaningless until the first startup rise
  always_ff @(posedge clk) begin
    if (step) begin
      low_prod_r <= low_prod_nxt;
      high_prod_r <= high_prod_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result.started = (startup_left_r == 2'd0);
  assign result.period_outlier = rise_bad_r;
  assign result.width_outlier = fall_bad_r;
  assign result.width_accepted = accepted_r;
  assign result.report = report_r;
  assign result.width_us = accepted_width_r;
  assign result.cycle_us = last_cycle_r;

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("transaction processed without a result");

  a_report_when_running: assert property (@(posedge clk) disable iff (!rst_n)
    report_r |-> (startup_left_r == 2'd0))
    else $error("width checked while starting");

  a_accept_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
    accepted_r |-> report_r)
    else $error("width accepted without a check");

  a_count_only_after_outlier: assert property (@(posedge clk) disable iff (!rst_n)
    (outlier_count_r != 4'd0) |-> (rise_bad_r && (outlier_count_r <= OUTLIER_RUN)))
    else $error("outlier counter out of step with rise flag");

endmodule

// ===== sv/rc_pwm_pulse_decoder.sv =====
// RC servo PWM decoder fed with timestamped pin edges, one transaction in and one result
// out per event. An input transaction carries the pin level after the edge and its 32-bit
// microsecond timestamp, or a restart command on in_tuser. While starting, each rising edge
// learns the period window from the rise-to-rise time; after three startup falling edges
// each rising edge is checked against that window and each falling edge after a good rise
// checks the high time against width_min..width_max. The block takes one transaction every
// clock cycle as long as its results are taken. The input register loads a transaction when
// it is accepted; the decode logic then updates the channel state and loads the result
// register, which drives out_tvalid, once the result output is free. A stalled result holds
// the decode stage, and the input register then absorbs one more transaction.
module rc_pwm_pulse_decoder
  import rpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // level, time_us, zero fill
  input  logic                   in_tuser,   // command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // started, period_outlier, width_outlier, width_accepted, report, width_us, cycle_us,
  // zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  rpd_cfg_t    cfg;
  rpd_item_t   item_r;
  rpd_result_t result;
  logic        item_valid_r;
  logic        out_free;
  logic        step;
  logic        in_take;

  assign out_free = !out_tvalid || out_tready;
  assign step = item_valid_r && out_free;
  assign in_tready = !item_valid_r || out_free;
  assign in_take = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (step) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.command <= in_tuser;
      item_r.level <= in_tdata[0];
      item_r.time_us <= in_tdata[TIME_W:1];
    end
  end

  rpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rpd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (item_r),
    .cfg        (cfg),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .result     (result)
  );

  assign out_tdata = {3'b000, result.cycle_us, result.width_us, result.report,
                      result.width_accepted, result.width_outlier,
                      result.period_outlier, result.started};

endmodule
